/* design/apts_pkg.sv */
// package for the audio pes transport stream packetizer
// holds sizes, stream constants, the command and config types and the back-end step codes
// no dependencies
package apts_pkg;

    // frame length field width
    localparam int FRAME_LEN_BITS = 18;

    // transport stream layout
    localparam int TS_PKT_LEN  = 188;
    localparam int TS_HDR_LEN  = 4;
    localparam int PES_HDR_LEN = 14;
    localparam int FIRST_ROOM  = TS_PKT_LEN - TS_HDR_LEN - PES_HDR_LEN;
    localparam int NEXT_ROOM   = TS_PKT_LEN - TS_HDR_LEN;

    // adts framing
    localparam int ADTS_LEN    = 7;
    localparam int AAC_MAX_LEN = 8184;
    localparam int PTS_BITS    = 33;
    localparam int PTS_PER_MS  = 90;

    // pes length limit, above it the length field is zero
    localparam logic [31:0] PES_LEN_LIMIT = 32'h0000_ffff;
    localparam int PES_LEN_EXTRA = 8;

    // stream byte constants
    localparam logic [7:0] TS_SYNC      = 8'h47;
    localparam logic [7:0] TS_START_BIT = 8'h40;
    localparam logic [7:0] TS_PAYLOAD   = 8'h10;
    localparam logic [7:0] TS_ADAPT     = 8'h20;
    localparam logic [7:0] PES_STREAM   = 8'hc0;
    localparam logic [7:0] PES_FLAGS    = 8'h80;
    localparam logic [7:0] PES_HLEN     = 8'h05;
    localparam logic [7:0] STUFF_BYTE   = 8'hff;
    localparam logic [7:0] ADTS_SYNC0   = 8'hff;
    localparam logic [7:0] ADTS_SYNC1   = 8'hf9;
    localparam logic [7:0] ADTS_TAIL    = 8'hfc;

    // command queue between front and back, depth is a power of two
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_BITS   = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_BITS   = $clog2(CMD_FIFO_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PID         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AAC_MODE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROFILE     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_RATE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL     = 3'd4;

    // configuration register file
    typedef struct packed {
        logic [12:0] pid;
        logic        aac_mode;
        logic [1:0]  audio_profile;
        logic [3:0]  sample_rate_index;
        logic [2:0]  channel_config;
    } cfg_t;

    // what the back end has to do for one request
    typedef enum logic [1:0] {
        CMD_ERR,
        CMD_BYTE,
        CMD_OPEN,
        CMD_FIRST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [7:0]                data;
        logic                      pkt_end;
        logic [7:0]                stuff;
        logic [3:0]                cc;
        logic [FRAME_LEN_BITS-1:0] total;
        logic [PTS_BITS-1:0]       pts;
    } cmd_t;

    // back-end emission steps, one result each
    typedef enum logic [4:0] {
        ST_H0, ST_H1, ST_H2, ST_H3,
        ST_AF_LEN, ST_AF_FLAGS, ST_AF_FILL,
        ST_PES0, ST_PES1, ST_PES2, ST_PES3, ST_PES4, ST_PES5, ST_PES6,
        ST_PES7, ST_PES8, ST_PES9, ST_PES10, ST_PES11, ST_PES12, ST_PES13,
        ST_ADTS0, ST_ADTS1, ST_ADTS2, ST_ADTS3, ST_ADTS4, ST_ADTS5, ST_ADTS6,
        ST_DATA,
        ST_ERR
    } step_t;

endpackage

/* design/apts_front.sv */
// front end: accepts input bytes, tracks frame and packet state, issues back-end commands
// depends on apts_pkg
module apts_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          audio_byte,
    input  logic                                frame_start,
    input  logic [apts_pkg::FRAME_LEN_BITS-1:0] frame_len,
    input  logic [31:0]                         timestamp_ms,
    input  logic                                aac_mode,
    input  logic                                fifo_full,
    output logic                                push,
    output apts_pkg::cmd_t                      push_cmd
);
    import apts_pkg::*;

    logic [3:0]                cc_reg, cc_next;
    logic [FRAME_LEN_BITS-1:0] remaining_reg, remaining_next;
    logic [7:0]                room_reg, room_next;
    logic                      dropping_reg, dropping_next;

    logic                      in_fire;
    logic                      is_err;
    logic                      opening;
    logic [FRAME_LEN_BITS-1:0] total;
    logic [FRAME_LEN_BITS-1:0] base;
    logic [FRAME_LEN_BITS-1:0] rem_after;
    logic [7:0]                room0;
    logic [7:0]                len;
    logic [7:0]                stuff;
    logic [7:0]                consumed;
    logic [7:0]                room_cur;
    logic [7:0]                room_after;
    logic [38:0]               pts_full;

    assign in_ready = !fifo_full;
    assign in_fire  = in_valid && in_ready;

    // pts = ms * 90, kept to 33 bits
    assign pts_full = {7'd0, timestamp_ms} * 39'(PTS_PER_MS);

    // packet sizing for the byte at the input
    always_comb
    begin
        total      = aac_mode ? frame_len + FRAME_LEN_BITS'(ADTS_LEN) : frame_len;
        is_err     = aac_mode && (frame_len == '0 ||
                                  frame_len > FRAME_LEN_BITS'(AAC_MAX_LEN));
        opening    = frame_start || room_reg == 8'd0;
        base       = frame_start ? total : remaining_reg;
        room0      = frame_start ? 8'(FIRST_ROOM) : 8'(NEXT_ROOM);
        len        = (base < FRAME_LEN_BITS'(room0)) ? base[7:0] : room0;
        stuff      = room0 - len;
        consumed   = (frame_start && aac_mode) ? 8'(ADTS_LEN + 1) : 8'd1;
        room_cur   = opening ? len : room_reg;
        room_after = room_cur - consumed;
        rem_after  = base - FRAME_LEN_BITS'(consumed);
    end

    // command contents
    always_comb
    begin
        push_cmd.kind    = CMD_BYTE;
        push_cmd.data    = audio_byte;
        push_cmd.pkt_end = room_after == 8'd0;
        push_cmd.stuff   = stuff;
        push_cmd.cc      = cc_reg + 4'd1;
        push_cmd.total   = total;
        push_cmd.pts     = pts_full[PTS_BITS-1:0];
        if (frame_start)
        begin
            push_cmd.kind = is_err ? CMD_ERR : CMD_FIRST;
        end
        else if (room_reg == 8'd0)
        begin
            push_cmd.kind = CMD_OPEN;
        end
    end

    // state update and push decision
    always_comb
    begin
        cc_next        = cc_reg;
        remaining_next = remaining_reg;
        room_next      = room_reg;
        dropping_next  = dropping_reg;
        push           = 1'b0;
        if (in_fire)
        begin
            if (frame_start)
            begin
                dropping_next  = 1'b0;
                remaining_next = '0;
                room_next      = 8'd0;
                if (is_err)
                begin
                    dropping_next = 1'b1;
                    push          = 1'b1;
                end
                else if (total != '0)
                begin
                    push           = 1'b1;
                    cc_next        = cc_reg + 4'd1;
                    remaining_next = rem_after;
                    room_next      = room_after;
                end
            end
            else if (!dropping_reg && remaining_reg != '0)
            begin
                push           = 1'b1;
                remaining_next = rem_after;
                room_next      = room_after;
                if (opening)
                begin
                    cc_next = cc_reg + 4'd1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg        <= 4'd0;
            remaining_reg <= '0;
            room_reg      <= 8'd0;
            dropping_reg  <= 1'b0;
        end
        else
        begin
            cc_reg        <= cc_next;
            remaining_reg <= remaining_next;
            room_reg      <= room_next;
            dropping_reg  <= dropping_next;
        end
    end

endmodule

/* design/apts_cmd_fifo.sv */
// short command queue between the front and back ends
// depends on apts_pkg
module apts_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  apts_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output apts_pkg::cmd_t head,
    output logic           empty
);
    import apts_pkg::*;

    cmd_t                    entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_BITS-1:0] count_reg, count_next;

    assign full  = count_reg == CMD_CNT_BITS'(CMD_FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/apts_back.sv */
// back end: expands each command into header, adaptation, pes, adts and data results, or an error result
// depends on apts_pkg
module apts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  apts_pkg::cfg_t cfg,
    input  apts_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic [7:0]     repeat_count,
    output logic           packet_end,
    output logic           frame_error,
    output logic           last
);
    import apts_pkg::*;

    step_t       step_reg, step_next;
    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [7:0]  repeat_reg, repeat_next;
    logic        pkt_end_reg, pkt_end_next;
    logic        err_reg, err_next;
    logic        last_reg, last_next;

    step_t       step_cur;
    step_t       step_after;
    step_t       step_tail;
    logic        first;
    logic        final_step;
    logic        load;
    logic [31:0] plen_w;
    logic [15:0] plen;
    logic [12:0] fl;

    assign first  = head.kind == CMD_FIRST;
    assign plen_w = 32'(head.total) + 32'(PES_LEN_EXTRA);
    assign plen   = (plen_w > PES_LEN_LIMIT) ? 16'd0 : plen_w[15:0];
    assign fl     = head.total[12:0];
    assign load   = head_valid && (!out_valid_reg || out_ready);

    // step sequencing, the last step is held while the queue is empty
    always_comb
    begin
        if (active_reg || !head_valid)
        begin
            step_cur = step_reg;
        end
        else
        begin
            unique case (head.kind)
                CMD_ERR:   step_cur = ST_ERR;
                CMD_BYTE:  step_cur = ST_DATA;
                CMD_OPEN:  step_cur = ST_H0;
                CMD_FIRST: step_cur = ST_H0;
            endcase
        end

        // where the fixed headers end
        step_tail  = first ? ST_PES0 : ST_DATA;
        final_step = step_cur == ST_DATA || step_cur == ST_ERR;

        unique case (step_cur)
            ST_H3:
            begin
                step_after = (head.stuff != 8'd0) ? ST_AF_LEN : step_tail;
            end
            ST_AF_LEN:
            begin
                step_after = (head.stuff >= 8'd2) ? ST_AF_FLAGS : step_tail;
            end
            ST_AF_FLAGS:
            begin
                step_after = (head.stuff > 8'd2) ? ST_AF_FILL : step_tail;
            end
            ST_AF_FILL:
            begin
                step_after = step_tail;
            end
            ST_PES13:
            begin
                step_after = cfg.aac_mode ? ST_ADTS0 : ST_DATA;
            end
            ST_ADTS6:
            begin
                step_after = ST_DATA;
            end
            ST_H0, ST_H1, ST_H2,
            ST_PES0, ST_PES1, ST_PES2, ST_PES3, ST_PES4, ST_PES5, ST_PES6,
            ST_PES7, ST_PES8, ST_PES9, ST_PES10, ST_PES11, ST_PES12,
            ST_ADTS0, ST_ADTS1, ST_ADTS2, ST_ADTS3, ST_ADTS4, ST_ADTS5:
            begin
                step_after = step_t'(step_cur + 5'd1);
            end
            default:
            begin
                step_after = ST_DATA;
            end
        endcase

        pop         = load && final_step;
        step_next   = step_reg;
        active_next = active_reg;
        if (load)
        begin
            step_next   = step_after;
            active_next = !final_step;
        end
    end

    // result fields for the current step
    always_comb
    begin
        out_byte_next = 8'd0;
        repeat_next   = 8'd1;
        pkt_end_next  = 1'b0;
        err_next      = 1'b0;
        last_next     = 1'b0;
        unique case (step_cur)
            ST_H0:       out_byte_next = TS_SYNC;
            ST_H1:       out_byte_next = {3'd0, cfg.pid[12:8]} | (first ? TS_START_BIT : 8'd0);
            ST_H2:       out_byte_next = cfg.pid[7:0];
            ST_H3:       out_byte_next = TS_PAYLOAD | {4'd0, head.cc} |
                                         ((head.stuff != 8'd0) ? TS_ADAPT : 8'd0);
            ST_AF_LEN:   out_byte_next = head.stuff - 8'd1;
            ST_AF_FLAGS: out_byte_next = 8'd0;
            ST_AF_FILL:
            begin
                out_byte_next = STUFF_BYTE;
                repeat_next   = head.stuff - 8'd2;
            end
            ST_PES0:     out_byte_next = 8'h00;
            ST_PES1:     out_byte_next = 8'h00;
            ST_PES2:     out_byte_next = 8'h01;
            ST_PES3:     out_byte_next = PES_STREAM;
            ST_PES4:     out_byte_next = plen[15:8];
            ST_PES5:     out_byte_next = plen[7:0];
            ST_PES6:     out_byte_next = PES_FLAGS;
            ST_PES7:     out_byte_next = PES_FLAGS;
            ST_PES8:     out_byte_next = PES_HLEN;
            ST_PES9:     out_byte_next = {4'b0010, head.pts[32:30], 1'b1};
            ST_PES10:    out_byte_next = head.pts[29:22];
            ST_PES11:    out_byte_next = {head.pts[21:15], 1'b1};
            ST_PES12:    out_byte_next = head.pts[14:7];
            ST_PES13:    out_byte_next = {head.pts[6:0], 1'b1};
            ST_ADTS0:    out_byte_next = ADTS_SYNC0;
            ST_ADTS1:    out_byte_next = ADTS_SYNC1;
            ST_ADTS2:    out_byte_next = {cfg.audio_profile, cfg.sample_rate_index, 1'b0,
                                          cfg.channel_config[2]};
            ST_ADTS3:    out_byte_next = {cfg.channel_config[1:0], 4'd0, fl[12:11]};
            ST_ADTS4:    out_byte_next = fl[10:3];
            ST_ADTS5:    out_byte_next = {fl[2:0], 5'h1f};
            ST_ADTS6:    out_byte_next = ADTS_TAIL;
            ST_DATA:
            begin
                out_byte_next = head.data;
                pkt_end_next  = head.pkt_end;
                last_next     = 1'b1;
            end
            ST_ERR:
            begin
                repeat_next = 8'd0;
                err_next    = 1'b1;
                last_next   = 1'b1;
            end
            default:     out_byte_next = 8'd0;
        endcase

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_H0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            repeat_reg   <= repeat_next;
            pkt_end_reg  <= pkt_end_next;
            err_reg      <= err_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign repeat_count = repeat_reg;
    assign packet_end   = pkt_end_reg;
    assign frame_error  = err_reg;
    assign last         = last_reg;

endmodule

/* design/audio_pes_ts_packetizer_core.sv */
// top level of the audio pes transport stream packetizer
// depends on apts_pkg, apts_front, apts_cmd_fifo and apts_back
//
// Audio frame bytes go in one per request; the byte flagged frame_start carries the frame
// length and a millisecond timestamp. Out come 188-byte transport packets, one result per
// byte, with a 0xff stuffing run as a single result carrying a repeat count. The front end
// takes one input byte per cycle whenever its four-entry command queue has room; the back
// end emits one result per cycle while a command is queued and the output port accepts, so
// the output port sets the sustained rate. A byte inside a packet yields one result, a byte
// that opens a packet 5 to 8 results (4 header bytes plus up to 3 adaptation-field results
// and the byte), and the first byte of a frame up to 29 (header, adaptation field, 14 PES
// bytes, 7 ADTS bytes in AAC mode, the byte itself). An AAC frame with a bad length yields
// a single error result. An accepted byte passes through the queue and then the output
// register. Configuration writes take effect at once and are meant for idle.
module audio_pes_ts_packetizer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [apts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [apts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          audio_byte,
    input  logic                                frame_start,
    input  logic [apts_pkg::FRAME_LEN_BITS-1:0] frame_len,
    input  logic [31:0]                         timestamp_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_byte,
    output logic [7:0]                          repeat_count,
    output logic                                packet_end,
    output logic                                frame_error,
    output logic                                last
);
    import apts_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    cmd_t push_cmd;
    logic fifo_full;
    logic fifo_empty;
    logic pop;
    cmd_t head;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PID:         cfg_next.pid               = cfg_data[12:0];
                REG_AAC_MODE:    cfg_next.aac_mode          = cfg_data[0];
                REG_PROFILE:     cfg_next.audio_profile     = cfg_data[1:0];
                REG_SAMPLE_RATE: cfg_next.sample_rate_index = cfg_data[3:0];
                REG_CHANNEL:     cfg_next.channel_config    = cfg_data[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pid               <= 13'd257;
            cfg_reg.aac_mode          <= 1'b1;
            cfg_reg.audio_profile     <= 2'd1;
            cfg_reg.sample_rate_index <= 4'd4;
            cfg_reg.channel_config    <= 3'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input classification
    apts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .audio_byte   (audio_byte),
        .frame_start  (frame_start),
        .frame_len    (frame_len),
        .timestamp_ms (timestamp_ms),
        .aac_mode     (cfg_reg.aac_mode),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // command queue
    apts_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    // result generation
    apts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (!fifo_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .repeat_count (repeat_count),
        .packet_end   (packet_end),
        .frame_error  (frame_error),
        .last         (last)
    );

endmodule

/* design/apts_checker.sv */
// port-level checks for the audio pes transport stream packetizer
// bound to audio_pes_ts_packetizer_core, no package dependency
module apts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [7:0] repeat_count,
    input logic       packet_end,
    input logic       frame_error,
    input logic       last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(repeat_count))
        else $error("output result changed while stalled");

    // error result has a fixed shape
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_error |->
            last && !packet_end && repeat_count == 8'd0 && out_byte == 8'd0)
        else $error("malformed frame error result");

    // a packet only ends on the data byte of a request
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_end |-> last && repeat_count == 8'd1 && !frame_error)
        else $error("packet end on a non-data result");

    // only stuffing runs repeat
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_error && repeat_count != 8'd1 |->
            out_byte == 8'hff && !last && repeat_count != 8'd0)
        else $error("repeat count outside a stuffing run");

endmodule

bind audio_pes_ts_packetizer_core apts_checker u_apts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .packet_end   (packet_end),
    .frame_error  (frame_error),
    .last         (last)
);
